### rtl/btlp_pkg.sv
// ----------------------------------------------------------------------------
// btlp_pkg
// shared types, constants and helpers of the two-level branch target predictor
// ----------------------------------------------------------------------------
package btlp_pkg;

    localparam int DATA_W          = 32;
    localparam int TAG_W           = 30;
    localparam int ENTRY_FIELD_W   = 10;   // holds any entry index up to 1024 entries
    localparam int PCX_W           = 16;   // widest history index
    localparam int MAX_ENTRIES_DEF = 32;
    localparam int MAX_HISTORY_DEF = 8;

    // counter value everywhere after reset
    localparam logic [1:0] CNT_RESET = 2'd1;

    localparam logic KIND_PREDICT = 1'b0;
    localparam logic KIND_UPDATE  = 1'b1;

    localparam logic [1:0] XOR_NONE = 2'd0;
    localparam logic [1:0] XOR_LOW  = 2'd1;
    localparam logic [1:0] XOR_HIGH = 2'd2;

    typedef enum logic [2:0] {
        REG_ENTRY_COUNT     = 3'd0,
        REG_HISTORY_BITS    = 3'd1,
        REG_TAG_BITS        = 3'd2,
        REG_DEFAULT_COUNTER = 3'd3,
        REG_SHARED_HISTORY  = 3'd4,
        REG_SHARED_COUNTERS = 3'd5,
        REG_XOR_MODE        = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [5:0] entry_count;
        logic [3:0] history_bits;
        logic [4:0] tag_bits;
        logic [1:0] default_counter;
        logic       shared_history;
        logic       shared_counters;
        logic [1:0] xor_mode;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [DATA_W-1:0] pc;
        logic [DATA_W-1:0] actual_target;
        logic              was_taken;
        logic [DATA_W-1:0] offered_target;
    } in_t;

    typedef struct packed {
        logic              predict_taken;
        logic [DATA_W-1:0] predicted_target;
        logic [DATA_W-1:0] branch_total;
        logic [DATA_W-1:0] flush_total;
    } out_t;

    // classified item handed from front to back
    typedef struct packed {
        in_t                      item;
        logic [ENTRY_FIELD_W-1:0] entry;
        logic [TAG_W-1:0]         tag;
        logic [PCX_W-1:0]         pcx;
        logic [DATA_W-1:0]        pc_plus4;
    } job_t;

    // history mask for the configured width, clamped to 1..max_h
    function automatic logic [PCX_W-1:0] hist_mask(input logic [3:0] bits, input int max_h);
        int h;
        h = int'(bits);
        if (h < 1) h = 1;
        if (h > max_h) h = max_h;
        hist_mask = PCX_W'((32'd1 << h) - 32'd1);
    endfunction

endpackage

### rtl/btlp_fifo.sv
// ----------------------------------------------------------------------------
// btlp_fifo
// two-entry queue with full and empty flags
// ----------------------------------------------------------------------------
module btlp_fifo #(
    parameter type T = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     data_in,
    output logic full,
    input  logic pop,
    output T     data_out,
    output logic empty
);

    T           mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)      count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push) count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) mem_reg[wr_ptr_reg] <= data_in;
    end

endmodule

### rtl/btlp_front.sv
// ----------------------------------------------------------------------------
// btlp_front
// classifies an incoming transaction: entry index, tag, xor bits, pc plus 4
// ----------------------------------------------------------------------------
module btlp_front #(
    parameter int MAX_ENTRIES = btlp_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_HISTORY = btlp_pkg::MAX_HISTORY_DEF
) (
    input  btlp_pkg::cfg_t cfg,
    input  btlp_pkg::in_t  item,
    output btlp_pkg::job_t job
);

    localparam int EF = btlp_pkg::ENTRY_FIELD_W;

    logic [EF:0]                   n_entries;
    logic [EF:0]                   e_mask;
    logic [EF:0]                   e_full;
    logic [4:0]                    t_bits;
    logic [btlp_pkg::TAG_W-1:0]    t_mask;
    logic [btlp_pkg::PCX_W-1:0]    h_mask;
    logic [btlp_pkg::PCX_W-1:0]    pc_sel;

    always_comb
    begin
        if (cfg.entry_count == 6'd0)
            n_entries = (EF+1)'(1);
        else if (32'(cfg.entry_count) > 32'(MAX_ENTRIES))
            n_entries = (EF+1)'(MAX_ENTRIES);
        else
            n_entries = (EF+1)'(cfg.entry_count);
        e_mask = n_entries - (EF+1)'(1);
        e_full = item.pc[EF+2:2] & e_mask;

        t_bits = (cfg.tag_bits > 5'd30) ? 5'd30 : cfg.tag_bits;
        t_mask = btlp_pkg::TAG_W'((64'd1 << t_bits) - 64'd1);

        h_mask = btlp_pkg::hist_mask(cfg.history_bits, MAX_HISTORY);
        case (cfg.xor_mode)
            btlp_pkg::XOR_LOW:  pc_sel = item.pc[btlp_pkg::PCX_W+1:2];
            btlp_pkg::XOR_HIGH: pc_sel = item.pc[btlp_pkg::PCX_W+15:16];
            default:            pc_sel = '0;
        endcase

        job.item     = item;
        job.entry    = e_full[EF-1:0];
        job.tag      = item.pc[btlp_pkg::TAG_W+1:2] & t_mask;
        job.pcx      = pc_sel & h_mask;
        job.pc_plus4 = item.pc + 32'd4;
    end

endmodule

### rtl/btlp_back.sv
// ----------------------------------------------------------------------------
// btlp_back
// executes classified transactions: row read, then predict or train
// ----------------------------------------------------------------------------
module btlp_back #(
    parameter int MAX_ENTRIES = btlp_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_HISTORY = btlp_pkg::MAX_HISTORY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  btlp_pkg::cfg_t cfg,
    input  logic           job_empty,
    input  btlp_pkg::job_t job,
    output logic           job_pop,
    input  logic           res_full,
    output logic           res_push,
    output btlp_pkg::out_t res
);

    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int HW = MAX_HISTORY;
    localparam int TD = 2 ** HW;
    localparam int RW = 2 * TD;

    typedef enum logic [1:0] {
        ST_READ = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                      state_reg;
    btlp_pkg::job_t              job_reg;
    logic [RW-1:0]               row_mem [MAX_ENTRIES];
    logic [RW-1:0]               row_rd_reg;
    logic                        row_valid_reg [MAX_ENTRIES];
    logic                        valid_reg [MAX_ENTRIES];
    logic [btlp_pkg::TAG_W-1:0]  tag_reg [MAX_ENTRIES];
    logic [btlp_pkg::DATA_W-1:0] target_reg [MAX_ENTRIES];
    logic [HW-1:0]               hist_reg [MAX_ENTRIES];
    logic                        last_guess_reg;
    logic [btlp_pkg::DATA_W-1:0] branch_reg;
    logic [btlp_pkg::DATA_W-1:0] flush_reg;

    logic                        go;
    logic [EW-1:0]               rd_tbl;
    logic [EW-1:0]               e;
    logic [EW-1:0]               hr;
    logic [EW-1:0]               tbl;
    logic                        upd;
    logic                        hit;
    logic                        install;
    logic [btlp_pkg::PCX_W-1:0]  m_full;
    logic [HW-1:0]               m;
    logic [RW-1:0]               row_eff;
    logic [RW-1:0]               row_new;
    logic [HW-1:0]               hist_eff;
    logic [HW-1:0]               hist_next;
    logic [HW-1:0]               idx;
    logic [1:0]                  cnt;
    logic [1:0]                  cnt_next;
    logic                        taken;
    logic                        mispredict;
    logic [btlp_pkg::DATA_W-1:0] branch_next;
    logic [btlp_pkg::DATA_W-1:0] flush_next;
    logic                        guess;

    assign go      = (state_reg == ST_READ) && !job_empty && !res_full;
    assign job_pop = go;
    assign rd_tbl  = cfg.shared_counters ? '0 : job.entry[EW-1:0];
    assign m_full  = btlp_pkg::hist_mask(cfg.history_bits, MAX_HISTORY);

    always_comb
    begin
        e       = job_reg.entry[EW-1:0];
        hr      = cfg.shared_history ? '0 : e;
        tbl     = cfg.shared_counters ? '0 : e;
        upd     = (job_reg.item.kind == btlp_pkg::KIND_UPDATE);
        taken   = job_reg.item.was_taken;
        hit     = valid_reg[e] && (tag_reg[e] == job_reg.tag);
        install = upd && !hit;
        m       = m_full[HW-1:0];

        // refilled table or never written row read as fill values
        if (install && !cfg.shared_counters)
            row_eff = {TD{cfg.default_counter}};
        else if (!row_valid_reg[tbl])
            row_eff = {TD{btlp_pkg::CNT_RESET}};
        else
            row_eff = row_rd_reg;

        hist_eff = (install && !cfg.shared_history) ? '0 : hist_reg[hr];
        idx      = (hist_eff & m) ^ (job_reg.pcx[HW-1:0] & m);
        cnt      = row_eff[{idx, 1'b0} +: 2];

        if (taken && cnt != 2'd3)       cnt_next = cnt + 2'd1;
        else if (!taken && cnt != 2'd0) cnt_next = cnt - 2'd1;
        else                            cnt_next = cnt;
        row_new = row_eff;
        row_new[{idx, 1'b0} +: 2] = cnt_next;
        hist_next = {hist_eff[HW-2:0], taken} & m;

        mispredict  = (last_guess_reg != taken) ||
                      (taken && job_reg.item.actual_target != job_reg.item.offered_target);
        branch_next = branch_reg + (upd ? 32'd1 : 32'd0);
        flush_next  = flush_reg + ((upd && mispredict) ? 32'd1 : 32'd0);
        guess       = hit && cnt[1];

        res_push = (state_reg == ST_EXEC);
        if (upd)
        begin
            res.predict_taken    = 1'b0;
            res.predicted_target = '0;
        end
        else
        begin
            res.predict_taken    = guess;
            res.predicted_target = guess ? target_reg[e] : job_reg.pc_plus4;
        end
        res.branch_total = branch_next;
        res.flush_total  = flush_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_READ;
            last_guess_reg <= 1'b0;
            branch_reg     <= '0;
            flush_reg      <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                valid_reg[i]     <= 1'b0;
                row_valid_reg[i] <= 1'b0;
                hist_reg[i]      <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_READ:
                begin
                    if (go) state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    state_reg  <= ST_READ;
                    branch_reg <= branch_next;
                    flush_reg  <= flush_next;
                    if (upd)
                    begin
                        valid_reg[e]       <= 1'b1;
                        row_valid_reg[tbl] <= 1'b1;
                        hist_reg[hr]       <= hist_next;
                    end
                    else
                    begin
                        last_guess_reg <= guess;
                    end
                end
                default: state_reg <= ST_READ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (go) job_reg <= job;
        if (state_reg == ST_EXEC && upd)
        begin
            tag_reg[e]    <= job_reg.tag;
            target_reg[e] <= job_reg.item.actual_target;
        end
    end

    // counter row memory
    always_ff @(posedge clk)
    begin
        if (go) row_rd_reg <= row_mem[rd_tbl];
        if (state_reg == ST_EXEC && upd) row_mem[tbl] <= row_new;
    end

`ifndef SYNTHESIS
    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC |=> state_reg == ST_READ)
        else $error("exec state held longer than one cycle");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");
    a_pop_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> state_reg == ST_READ && !job_empty)
        else $error("job popped outside read state");
`endif

endmodule

### rtl/two_level_branch_target_predictor.sv
// ----------------------------------------------------------------------------
// two_level_branch_target_predictor
// direct-mapped branch target buffer with two-level direction prediction
// ----------------------------------------------------------------------------
//  channel  | signals                              | transaction when
//  ---------+--------------------------------------+-------------------------
//  input    | push, full, item (in_t)              | push && !full
//  result   | pop, empty, result (out_t)           | pop && !empty
//  config   | cfg_valid, cfg_ready, cfg_index/data | cfg_valid && cfg_ready
//
//  each transaction passes through two back-end states: a counter row read,
//  then predict or train with write-back of the row
//  the front classifies and feeds a two-entry job queue, results wait in a
//  two-entry result queue, so input and output stall independently
//  reset clears valid bits, histories and counters at once; rows that were
//  never written read as the reset counter value, so no clearing pass
module two_level_branch_target_predictor #(
    parameter int MAX_ENTRIES = btlp_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_HISTORY = btlp_pkg::MAX_HISTORY_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  btlp_pkg::in_t  item,
    input  logic           pop,
    output logic           empty,
    output btlp_pkg::out_t result,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [7:0]     cfg_data
);

    btlp_pkg::cfg_t cfg_reg;
    btlp_pkg::job_t job_in;
    btlp_pkg::job_t job_out;
    btlp_pkg::out_t res;
    logic           job_empty;
    logic           job_pop;
    logic           res_full;
    logic           res_push;

    // config writes always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.entry_count     <= 6'd32;
            cfg_reg.history_bits    <= 4'd8;
            cfg_reg.tag_bits        <= 5'd30;
            cfg_reg.default_counter <= 2'd1;
            cfg_reg.shared_history  <= 1'b0;
            cfg_reg.shared_counters <= 1'b0;
            cfg_reg.xor_mode        <= btlp_pkg::XOR_NONE;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (btlp_pkg::reg_index_t'(cfg_index))
                btlp_pkg::REG_ENTRY_COUNT:     cfg_reg.entry_count     <= cfg_data[5:0];
                btlp_pkg::REG_HISTORY_BITS:    cfg_reg.history_bits    <= cfg_data[3:0];
                btlp_pkg::REG_TAG_BITS:        cfg_reg.tag_bits        <= cfg_data[4:0];
                btlp_pkg::REG_DEFAULT_COUNTER: cfg_reg.default_counter <= cfg_data[1:0];
                btlp_pkg::REG_SHARED_HISTORY:  cfg_reg.shared_history  <= cfg_data[0];
                btlp_pkg::REG_SHARED_COUNTERS: cfg_reg.shared_counters <= cfg_data[0];
                btlp_pkg::REG_XOR_MODE:        cfg_reg.xor_mode        <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // classify incoming transactions
    btlp_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_HISTORY (MAX_HISTORY)
    ) u_front (
        .cfg  (cfg_reg),
        .item (item),
        .job  (job_in)
    );

    // decoupling queue between front and back
    btlp_fifo #(
        .T (btlp_pkg::job_t)
    ) u_job_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .data_in  (job_in),
        .full     (full),
        .pop      (job_pop),
        .data_out (job_out),
        .empty    (job_empty)
    );

    // predict and train
    btlp_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_HISTORY (MAX_HISTORY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res)
    );

    // results wait here until popped
    btlp_fifo #(
        .T (btlp_pkg::out_t)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  (res),
        .full     (res_full),
        .pop      (pop),
        .data_out (result),
        .empty    (empty)
    );

endmodule

### dv/two_level_branch_target_predictor_checker.sv
// ----------------------------------------------------------------------------
// two_level_branch_target_predictor_checker
// watches the input, result and config channels of the branch target
// predictor, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module two_level_branch_target_predictor_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic           full,
    input  btlp_pkg::in_t  item,
    input  logic           pop,
    input  logic           empty,
    input  btlp_pkg::out_t result,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [7:0]     cfg_data,
    output int             fail_count,
    output int             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NENT = 32;
    localparam int TDEPTH = 256;

    logic [5:0]  m_entry_count;
    logic [3:0]  m_history_bits;
    logic [4:0]  m_tag_bits;
    logic [1:0]  m_default_counter;
    logic        m_shared_history;
    logic        m_shared_counters;
    logic [1:0]  m_xor_mode;

    logic        btb_valid [NENT];
    logic [29:0] btb_tag [NENT];
    logic [31:0] btb_target [NENT];
    logic [7:0]  btb_history [NENT];
    logic [1:0]  dir_counter [NENT*TDEPTH];
    logic        last_guess;
    logic [31:0] branch_count;
    logic [31:0] flush_count;

    btlp_pkg::out_t expected_results [$];

    assign pending_count = expected_results.size();

    function automatic int slot_of(logic [31:0] pc);
        int n;
        n = int'(m_entry_count);
        if (n < 1) n = 1;
        if (n > NENT) n = NENT;
        return int'(pc[31:2]) & (n - 1);
    endfunction

    function automatic logic [7:0] hmask();
        int h;
        h = int'(m_history_bits);
        if (h < 1) h = 1;
        if (h > 8) h = 8;
        return 8'((1 << h) - 1);
    endfunction

    function automatic logic [29:0] tag_of(logic [31:0] pc);
        int t;
        t = int'(m_tag_bits);
        if (t > 30) t = 30;
        return 30'((pc >> 2) & ((64'd1 << t) - 64'd1));
    endfunction

    function automatic int counter_pos(logic [31:0] pc, int e);
        int hr;
        int tb;
        logic [7:0] idx;
        hr = m_shared_history ? 0 : e;
        tb = m_shared_counters ? 0 : e;
        idx = btb_history[hr] & hmask();
        if (m_xor_mode == btlp_pkg::XOR_LOW) idx ^= pc[9:2] & hmask();
        else if (m_xor_mode == btlp_pkg::XOR_HIGH) idx ^= pc[23:16] & hmask();
        return tb * TDEPTH + int'(idx);
    endfunction

    task automatic reset_model();
        m_entry_count = 6'd32;
        m_history_bits = 4'd8;
        m_tag_bits = 5'd30;
        m_default_counter = btlp_pkg::CNT_RESET;
        m_shared_history = 1'b0;
        m_shared_counters = 1'b0;
        m_xor_mode = btlp_pkg::XOR_NONE;
        for (int i = 0; i < NENT; i++)
        begin
            btb_valid[i] = 1'b0;
            btb_tag[i] = '0;
            btb_target[i] = '0;
            btb_history[i] = '0;
        end
        for (int i = 0; i < NENT*TDEPTH; i++)
            dir_counter[i] = btlp_pkg::CNT_RESET;
        last_guess = 1'b0;
        branch_count = '0;
        flush_count = '0;
    endtask

    // predicts the result of one accepted transaction and updates state
    function automatic btlp_pkg::out_t predict_branch(btlp_pkg::in_t it);
        btlp_pkg::out_t r;
        int e;
        int pos;
        int hr;
        logic hit;
        logic [1:0] c;
        e = slot_of(it.pc);
        hit = btb_valid[e] && btb_tag[e] == tag_of(it.pc);
        r = '0;
        if (it.kind == btlp_pkg::KIND_PREDICT)
        begin
            pos = counter_pos(it.pc, e);
            if (hit && dir_counter[pos] >= 2)
            begin
                last_guess = 1'b1;
                r.predict_taken = 1'b1;
                r.predicted_target = btb_target[e];
            end
            else
            begin
                last_guess = 1'b0;
                r.predicted_target = it.pc + 32'd4;
            end
        end
        else
        begin
            hr = m_shared_history ? 0 : e;
            branch_count++;
            if (last_guess != it.was_taken ||
                (it.was_taken && it.actual_target != it.offered_target))
                flush_count++;
            if (!hit)
            begin
                btb_valid[e] = 1'b1;
                btb_tag[e] = tag_of(it.pc);
                if (!m_shared_counters)
                    for (int i = 0; i < TDEPTH; i++)
                        dir_counter[e*TDEPTH + i] = m_default_counter;
                if (!m_shared_history) btb_history[e] = '0;
            end
            pos = counter_pos(it.pc, e);
            c = dir_counter[pos];
            if (it.was_taken && c < 3) c++;
            else if (!it.was_taken && c > 0) c--;
            dir_counter[pos] = c;
            btb_history[hr] = {btb_history[hr][6:0], it.was_taken} & hmask();
            btb_target[e] = it.actual_target;
        end
        r.branch_total = branch_count;
        r.flush_total = flush_count;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("tb: mismatch %s got %h want %h", what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        reset_model();
    end

    always @(posedge clk)
    begin
        btlp_pkg::out_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                case (btlp_pkg::reg_index_t'(cfg_index))
                    btlp_pkg::REG_ENTRY_COUNT:     m_entry_count = cfg_data[5:0];
                    btlp_pkg::REG_HISTORY_BITS:    m_history_bits = cfg_data[3:0];
                    btlp_pkg::REG_TAG_BITS:        m_tag_bits = cfg_data[4:0];
                    btlp_pkg::REG_DEFAULT_COUNTER: m_default_counter = cfg_data[1:0];
                    btlp_pkg::REG_SHARED_HISTORY:  m_shared_history = cfg_data[0];
                    btlp_pkg::REG_SHARED_COUNTERS: m_shared_counters = cfg_data[0];
                    btlp_pkg::REG_XOR_MODE:        m_xor_mode = cfg_data[1:0];
                    default: ;
                endcase
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("tb: unexpected result transaction");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.predict_taken !== want.predict_taken)
                        report_mismatch("predict_taken", 32'(result.predict_taken),
                                        32'(want.predict_taken));
                    if (result.predicted_target !== want.predicted_target)
                        report_mismatch("predicted_target", result.predicted_target,
                                        want.predicted_target);
                    if (result.branch_total !== want.branch_total)
                        report_mismatch("branch_total", result.branch_total,
                                        want.branch_total);
                    if (result.flush_total !== want.flush_total)
                        report_mismatch("flush_total", result.flush_total,
                                        want.flush_total);
                end
            end
            if (push && !full)
                expected_results.push_back(predict_branch(item));
        end
    end
endmodule

### dv/two_level_branch_target_predictor_test.sv
// ----------------------------------------------------------------------------
// two_level_branch_target_predictor_test
// drives predict and update transactions through several register settings
// and idling phases; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module two_level_branch_target_predictor_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic           clk;
    logic           rst_n;
    logic           push;
    logic           full;
    btlp_pkg::in_t  item;
    logic           pop;
    logic           empty;
    btlp_pkg::out_t result;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [2:0]     cfg_index;
    logic [7:0]     cfg_data;
    int             fail_count;
    int             pending_count;

    // idle percentages per side, changed between phases
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int quiet_cycles;

    // small pool of branch addresses so entries hit, miss and alias
    logic [31:0] pc_pool [16];

    two_level_branch_target_predictor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .pop       (pop),
        .empty     (empty),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    two_level_branch_target_predictor_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .pop           (pop),
        .empty         (empty),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver: random stall, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one transaction on the input channel, with a random gap before it;
    // push stays high afterwards until the next caller lowers or reuses it
    task automatic send_item(btlp_pkg::in_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic write_reg(btlp_pkg::reg_index_t idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // wait until every expected result has come, then let the pipe drain
    task automatic drain();
        push <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] ec, logic [7:0] hb, logic [7:0] tb,
                              logic [7:0] dc, logic [7:0] sh, logic [7:0] sc,
                              logic [7:0] xm);
        drain();
        write_reg(btlp_pkg::REG_ENTRY_COUNT, ec);
        write_reg(btlp_pkg::REG_HISTORY_BITS, hb);
        write_reg(btlp_pkg::REG_TAG_BITS, tb);
        write_reg(btlp_pkg::REG_DEFAULT_COUNTER, dc);
        write_reg(btlp_pkg::REG_SHARED_HISTORY, sh);
        write_reg(btlp_pkg::REG_SHARED_COUNTERS, sc);
        write_reg(btlp_pkg::REG_XOR_MODE, xm);
        cfg_valid <= 1'b0;
    endtask

    function automatic btlp_pkg::in_t make_predict(logic [31:0] pc);
        btlp_pkg::in_t it;
        it = '0;
        it.kind = btlp_pkg::KIND_PREDICT;
        it.pc = pc;
        it.actual_target = $urandom;
        it.offered_target = $urandom;
        it.was_taken = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic btlp_pkg::in_t make_update(logic [31:0] pc, logic tk,
                                                  logic [31:0] tgt, logic [31:0] off);
        btlp_pkg::in_t it;
        it.kind = btlp_pkg::KIND_UPDATE;
        it.pc = pc;
        it.was_taken = tk;
        it.actual_target = tgt;
        it.offered_target = off;
        return it;
    endfunction

    // mostly predict-then-update pairs on pooled addresses, some noise
    task automatic random_burst(int count);
        logic [31:0] pc;
        logic [31:0] tgt;
        logic [31:0] off;
        int sel;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            pc = (sel < 85) ? pc_pool[$urandom_range(15)] : $urandom;
            tgt = $urandom_range(1) ? pc_pool[$urandom_range(15)] + 32'h40 : $urandom;
            off = $urandom_range(3) != 0 ? tgt : $urandom;
            if (sel < 70)
            begin
                send_item(make_predict(pc));
                send_item(make_update(pc, $urandom_range(3) != 0, tgt, off));
                n++;
            end
            else if (sel < 85)
                send_item(make_update(pc, 1'($urandom_range(1)), tgt, off));
            else
                send_item(make_predict(pc));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        quiet_cycles = 0;
        for (int i = 0; i < 16; i++)
            pc_pool[i] = {$urandom_range(3) == 0 ? 16'($urandom) : 16'h0040,
                          16'($urandom)};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, misses, hits, flush cases, pc+4 wrap
        send_item(make_predict(32'hffff_fffc));
        send_item(make_predict(32'h0000_0000));
        send_item(make_update(32'h0000_1000, 1'b1, 32'hffff_ffff, 32'hffff_ffff));
        send_item(make_update(32'h0000_1000, 1'b1, 32'h0000_2000, 32'h0000_2000));
        send_item(make_predict(32'h0000_1000));
        send_item(make_update(32'h0000_1000, 1'b1, 32'h0000_0000, 32'h0000_0000));
        send_item(make_update(32'h0000_1000, 1'b1, 32'h1234_5678, 32'h8765_4321));
        send_item(make_predict(32'h0000_1000));
        send_item(make_update(32'h0000_1000, 1'b0, 32'h0, 32'hffff_ffff));
        send_item(make_update(32'hffff_ffff, 1'b0, 32'hffff_ffff, 32'h0));
        send_item(make_predict(32'hffff_ffff));
        send_item(make_update(32'h8000_1000, 1'b1, 32'haaaa_5555, 32'haaaa_5555));
        send_item(make_predict(32'h0000_1000));
        send_item(make_predict(32'h8000_1000));
        send_item(make_update(32'h5555_aaaa, 1'b1, 32'h5555_aaaa, 32'h5555_aaaa));
        send_item(make_update(32'h5555_aaaa, 1'b1, 32'h5555_aaaa, 32'h5555_aaaa));
        send_item(make_predict(32'h5555_aaaa));

        // out-of-range and extreme register settings
        set_config(8'd0, 8'd0, 8'd31, 8'd3, 8'd1, 8'd1, 8'd3);
        send_item(make_update(32'h0000_1004, 1'b1, 32'h100, 32'h100));
        send_item(make_predict(32'h0000_1008));
        send_item(make_predict(32'h0000_1004));
        set_config(8'd63, 8'd15, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1);
        send_item(make_update(32'h0000_2004, 1'b1, 32'h200, 32'h200));
        send_item(make_predict(32'h7777_2004));

        // phase: no idling, reset-like settings
        set_config(8'd32, 8'd8, 8'd30, 8'd1, 8'd0, 8'd0, 8'd0);
        random_burst(350);

        // phase: sender idle, small table, xor with low pc bits
        set_config(8'd4, 8'd3, 8'd5, 8'd2, 8'd0, 8'd0, 8'd1);
        send_idle_pct = 74;
        random_burst(350);

        // phase: receiver stalling, shared history, xor high
        set_config(8'd1, 8'd1, 8'd30, 8'd0, 8'd1, 8'd0, 8'd2);
        send_idle_pct = 0;
        recv_stall_pct = 74;
        random_burst(350);

        // long hold-off on the receiver so the block fills and stalls input
        hold_off_cycles = 300;
        random_burst(40);

        // phase: both idling, shared counters, non power of two entries
        set_config(8'd6, 8'd8, 8'd2, 8'd3, 8'd0, 8'd1, 8'd1);
        send_idle_pct = 17;
        recv_stall_pct = 17;
        random_burst(350);

        // phase: fully shared, no idling
        set_config(8'd16, 8'd5, 8'd12, 8'd1, 8'd1, 8'd1, 8'd2);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_burst(350);

        drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
